/* src/ffc_pkg.sv */
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the frame
// check sequence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ffc_pkg;

  // Field widths fixed by the frame format.
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 11;
  localparam int ADDR_W   = 48;
  localparam int CRC_W    = 32;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 3;

  // Frame layout in bytes.
  localparam int ADDR_BYTES   = 6;
  localparam int LEN_POS      = 12;
  localparam int HDR_BYTES    = 14;
  localparam int FCS_BYTES    = 4;

  // Default configuration.
  localparam int MAX_PAYLOAD_DEF = 1500;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  // What the back end does with one classified word.
  typedef enum logic [2:0] {
    ACT_ADDR    = 3'd0,  // destination byte: CRC and address compare
    ACT_HDR     = 3'd1,  // other header byte: CRC only
    ACT_PAY     = 3'd2,  // payload byte: CRC and pass out
    ACT_FCS     = 3'd3,  // FCS byte: collect
    ACT_FCS_END = 3'd4,  // last FCS byte: collect and report status
    ACT_LEN_ERR = 3'd5   // length field too large: report status
  } ffc_act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_GOOD     = 2'd0,
    ST_LEN_BAD  = 2'd1,
    ST_FCS_BAD  = 2'd2,
    ST_ADDR_BAD = 2'd3
  } ffc_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } ffc_kind_t;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    ffc_act_t             act;
    logic                 start;
    logic [IDX_W-1:0]     idx;
    logic [DATA_W-1:0]    data;
    logic [LEN_W-1:0]     len;
  } ffc_cmd_t;

  // Result word as seen on the output queue.
  typedef struct packed {
    ffc_kind_t            kind;
    logic [DATA_W-1:0]    payload_byte;
    ffc_status_t          status;
    logic [LEN_W-1:0]     length;
  } ffc_res_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
    for (int k = 0; k < DATA_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/ffc_fifo.sv */
// ----------------------------------------------------------------------------
// ffc_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  // Occupancy never goes past the depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("ffc_fifo: occupancy above depth");

  // A write into an empty queue shows up at the head next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (empty && wr_en) |=> (!empty && rd_data == $past(wr_data)))
    else $error("ffc_fifo: written word not at head");

  // Pointers agree with the count when the queue is empty.
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> (wr_ptr_r == rd_ptr_r))
    else $error("ffc_fifo: pointers differ while empty");
`endif

endmodule

`default_nettype wire

/* src/ffc_front.sv */
// ----------------------------------------------------------------------------
// ffc_front
// Frame parser: tracks the position within the frame, captures the length
// field and tags each accepted byte with the action the back end performs.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_front import ffc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [DATA_W-1:0] data_byte,
  input  wire logic              frame_start,
  output logic                   cmd_push,
  output ffc_cmd_t               cmd
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_FCS     = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt, ph;
  logic [LEN_W-1:0]  count_r, count_nxt, cnt, cnt_inc;
  logic [15:0]       len_r, len_nxt, len_cur;

  // A start byte restarts the frame regardless of the current phase.
  assign ph      = frame_start ? PH_HEADER : phase_r;
  assign cnt     = frame_start ? '0 : count_r;
  assign len_cur = frame_start ? '0 : len_r;
  assign cnt_inc = cnt + 1'b1;

  // Classify the byte and advance the frame position.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    cmd_push  = 1'b0;
    cmd.act   = ACT_HDR;
    cmd.start = frame_start;
    cmd.idx   = cnt[IDX_W-1:0];
    cmd.data  = data_byte;
    cmd.len   = len_cur[LEN_W-1:0];
    if (accept) begin
      phase_nxt = ph;
      count_nxt = cnt;
      len_nxt   = len_cur;
      unique case (ph)
        PH_HEADER: begin
          cmd_push = 1'b1;
          cmd.act  = (cnt < LEN_W'(ADDR_BYTES)) ? ACT_ADDR : ACT_HDR;
          if (cnt >= LEN_W'(LEN_POS)) begin
            len_nxt = {len_cur[7:0], data_byte};
          end
          if (cnt_inc == LEN_W'(HDR_BYTES)) begin
            count_nxt = '0;
            if (len_nxt > 16'(MAX_PAYLOAD)) begin
              cmd.act   = ACT_LEN_ERR;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = (len_nxt == '0) ? PH_FCS : PH_PAYLOAD;
            end
          end else begin
            count_nxt = cnt_inc;
          end
        end
        PH_PAYLOAD: begin
          cmd_push = 1'b1;
          cmd.act  = ACT_PAY;
          if (16'(cnt_inc) >= len_cur) begin
            count_nxt = '0;
            phase_nxt = PH_FCS;
          end else begin
            count_nxt = cnt_inc;
          end
        end
        PH_FCS: begin
          cmd_push = 1'b1;
          if (cnt_inc == LEN_W'(FCS_BYTES)) begin
            cmd.act   = ACT_FCS_END;
            count_nxt = '0;
            phase_nxt = PH_IDLE;
          end else begin
            cmd.act   = ACT_FCS;
            count_nxt = cnt_inc;
          end
        end
        PH_IDLE: begin
          // Bytes outside a frame are dropped.
          cmd_push = 1'b0;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
    end
  end

`ifndef SYNTHESIS
  // A start byte always produces a word for the back end.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_start) |-> (cmd_push && cmd.start))
    else $error("ffc_front: start byte not forwarded");

  // The header position never runs past the header.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (count_r < LEN_W'(HDR_BYTES)))
    else $error("ffc_front: header count out of range");

  // Payload is only entered with a legal nonzero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (len_r != '0 && len_r <= 16'(MAX_PAYLOAD)))
    else $error("ffc_front: payload phase with bad length");
`endif

endmodule

`default_nettype wire

/* src/ffc_back.sv */
// ----------------------------------------------------------------------------
// ffc_back
// Frame checker: runs the CRC, compares the destination address, collects
// the received FCS and builds payload and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_back import ffc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_wr_data,
  input  wire ffc_cmd_t          cmd,
  input  wire logic              cmd_valid,
  output logic                   cmd_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output ffc_res_t               res
);

  logic [ADDR_W-1:0] local_addr_r;
  logic [CRC_W-1:0]  crc_r, crc_nxt, crc_base, crc_upd;
  logic [CRC_W-1:0]  fcs_r, fcs_nxt, fcs_base;
  logic              mism_r, mism_nxt, mism_base;
  logic [DATA_W-1:0] want;

  assign cmd_pop   = cmd_valid & ~res_full;
  assign crc_base  = cmd.start ? CRC_INIT : crc_r;
  assign fcs_base  = cmd.start ? '0 : fcs_r;
  assign mism_base = cmd.start ? 1'b0 : mism_r;
  assign crc_upd   = crc_byte(crc_base, cmd.data);

  // Station address byte for the current destination position.
  always_comb begin
    unique case (cmd.idx)
      3'd0:    want = local_addr_r[47:40];
      3'd1:    want = local_addr_r[39:32];
      3'd2:    want = local_addr_r[31:24];
      3'd3:    want = local_addr_r[23:16];
      3'd4:    want = local_addr_r[15:8];
      default: want = local_addr_r[7:0];
    endcase
  end

  // Carry out one classified word.
  always_comb begin
    crc_nxt          = crc_base;
    fcs_nxt          = fcs_base;
    mism_nxt         = mism_base;
    res_push         = 1'b0;
    res.kind         = KIND_STATUS;
    res.payload_byte = '0;
    res.status       = ST_GOOD;
    res.length       = '0;
    unique case (cmd.act)
      ACT_ADDR: begin
        crc_nxt = crc_upd;
        if (want != cmd.data) begin
          mism_nxt = 1'b1;
        end
      end
      ACT_HDR: begin
        crc_nxt = crc_upd;
      end
      ACT_PAY: begin
        crc_nxt          = crc_upd;
        res_push         = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = cmd.data;
      end
      ACT_FCS: begin
        fcs_nxt = {fcs_base[CRC_W-DATA_W-1:0], cmd.data};
      end
      ACT_FCS_END: begin
        fcs_nxt  = {fcs_base[CRC_W-DATA_W-1:0], cmd.data};
        res_push = 1'b1;
        if (fcs_nxt != ~crc_base) begin
          res.status = ST_FCS_BAD;
        end else if (mism_base) begin
          res.status = ST_ADDR_BAD;
        end else begin
          res.status = ST_GOOD;
          res.length = cmd.len;
        end
      end
      ACT_LEN_ERR: begin
        res_push   = 1'b1;
        res.status = ST_LEN_BAD;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
    res_push = res_push & cmd_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      crc_r        <= CRC_INIT;
      fcs_r        <= '0;
      mism_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        local_addr_r <= cfg_wr_data;
      end
      if (cmd_pop) begin
        crc_r  <= crc_nxt;
        fcs_r  <= fcs_nxt;
        mism_r <= mism_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // A result is only produced while the result queue has room.
  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("ffc_back: result pushed into full queue");

  // A failed status never carries a length; only a good status reports one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.kind == KIND_STATUS && res.status != ST_GOOD) |-> (res.length == '0))
    else $error("ffc_back: failed frame reports a length");

  // A start word resets the address check before it is evaluated.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.start && cmd.act == ACT_ADDR && want == cmd.data) |=> !mism_r)
    else $error("ffc_back: stale address mismatch after frame start");
`endif

endmodule

`default_nettype wire

/* src/frame_fcs_checker.sv */
// ----------------------------------------------------------------------------
// frame_fcs_checker
// Receives a length-type frame one byte per word, checks its CRC-32 FCS,
// length and destination address, and passes payload bytes through.
//
// Input channel: present in_data_byte and in_frame_start with in_push; a word
// is taken at a clock edge where in_push is high and in_full is low. A word
// with in_frame_start set opens a new frame and aborts any frame in progress.
// Result channel: while out_empty is low the oldest result sits on the out_
// ports; raise out_pop to take it. Each payload byte gives one result of
// kind 0, and each frame ends with one status result of kind 1 (after the
// last FCS byte, or right after the length bytes if the length is too big).
// Configuration: cfg_wr_en writes cfg_wr_data as the station address; write
// it only while no frame is in flight.
// A result is visible once it is written into the output queue, after its
// word has passed the parser's queue. One byte per cycle is sustained while
// the receiver pops; the per-byte CRC update in the back end is the longest
// path. A short queue sits between parser and checker and another ahead of
// the output; if the receiver stops popping, both fill and in_full rises.
// Reset (rst_n low, synchronous) empties both queues, returns the parser to
// idle and clears the station address to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_fcs_checker import ffc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_wr_data,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [DATA_W-1:0] in_data_byte,
  input  wire logic              in_frame_start,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic                   out_result_kind,
  output logic [DATA_W-1:0]      out_payload_byte,
  output logic [STAT_W-1:0]      out_frame_status,
  output logic [LEN_W-1:0]       out_payload_length
);

  localparam int CMD_W = $bits(ffc_cmd_t);
  localparam int RES_W = $bits(ffc_res_t);

  logic       accept;
  logic       cmd_push, cmd_pop, cmd_empty;
  ffc_cmd_t   cmd_in, cmd_out;
  logic       res_push, res_full;
  ffc_res_t   res_in, res_out;

  assign accept = in_push & ~in_full;

  // Front end: parse and classify.
  ffc_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  // Queue between parser and checker.
  ffc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (in_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Back end: CRC, address check and result building.
  ffc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_out),
    .cmd_valid   (~cmd_empty),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res_in)
  );

  // Output queue.
  ffc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_out),
    .empty   (out_empty)
  );

  assign out_result_kind    = res_out.kind;
  assign out_payload_byte   = res_out.payload_byte;
  assign out_frame_status   = res_out.status;
  assign out_payload_length = res_out.length;

endmodule

`default_nettype wire
